>>> hw/rtl/lmkg_pkg.sv
// shared constants and types for the logistic map key generator
package lmkg_pkg;
    localparam int ROUNDS = 16;
    localparam int RND_W = 4;
    localparam int CNT_W = 4;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_GEN = 1'b1;
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

    typedef struct packed {
        logic start;
        logic [127:0] x;
    } t_mul_req;

    typedef struct packed {
        logic done;
        logic [255:0] prod;
    } t_mul_rsp;
endpackage

>>> hw/rtl/lmkg_mul.sv
// shared 32x32 limb multiplier computing 4*x*(2^128-x) mod 2^256 over sixteen passes
module lmkg_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lmkg_pkg::t_mul_req i_req,
    output lmkg_pkg::t_mul_rsp o_rsp
);
    logic [127:0] r_a, r_b;
    logic [255:0] r_r, n_r;
    logic [1:0]   r_i, r_j;
    logic [31:0]  r_c;
    logic         r_busy, r_done;
    logic [31:0]  w_ai, w_bj, w_ri;
    logic [2:0]   w_idx;
    logic [63:0]  w_pp;
    logic [63:0]  w_t;

    assign w_ai  = r_a[{r_i, 5'd0} +: 32];
    assign w_bj  = r_b[{r_j, 5'd0} +: 32];
    assign w_idx = {1'b0, r_i} + {1'b0, r_j};
    assign w_ri  = r_r[{w_idx, 5'd0} +: 32];
    assign w_pp  = w_ai * w_bj;
    // limb product plus column and carry always fits in 64 bits
    assign w_t   = w_pp + {32'd0, w_ri} + {32'd0, r_c};

    always_comb begin
        n_r = r_r;
        n_r[{w_idx, 5'd0} +: 32] = w_t[31:0];
        // end of a row: carry out lands in the still untouched column i+4
        if (r_j == 2'd3) n_r[{1'b1, r_i, 5'd0} +: 32] = w_t[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i <= '0;
            r_j <= '0;
            r_c <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a <= i_req.x;
                r_b <= 128'd0 - i_req.x;
                r_r <= '0;
                r_i <= '0;
                r_j <= '0;
                r_c <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r <= n_r;
                r_j <= r_j + 2'd1;
                if (r_j == 2'd3) begin
                    r_c <= '0;
                    r_i <= r_i + 2'd1;
                    if (r_i == 2'd3) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_c <= w_t[63:32];
                end
            end
        end
    end

    assign o_rsp = {r_done, r_r[253:0], 2'b00};

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("start while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done longer than one cycle");
    a_row_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_j == 2'd0 |-> r_c == 32'd0)
        else $error("carry left at row start");
endmodule

>>> hw/rtl/logistic_map_key_generator.sv
// top level: logistic map key generator with a sequencer around the shared multiplier
// generate: each map step is start, sixteen 32x32 limb passes, completion and
//   write-back, over sixteen rounds of (count+1) steps until the key is valid in the
//   output register
// throughput: one item at a time; a waiting key only holds back the next key write-back
// reset: synchronous active low; state cleared to zero, round counts set to all ones
module logistic_map_key_generator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // seed_part[1:0], seed_value[65:2], zero fill
    input  logic         s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // key_high[63:0], key_low[127:64]
    input  logic         i_cfg_we,
    input  logic [63:0]  i_cfg_wdata
);
    typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_WRITE} t_state;

    t_state r_state;
    logic [63:0]  r_counts;
    logic [255:0] r_st;
    logic [lmkg_pkg::RND_W-1:0] r_rnd;
    logic [lmkg_pkg::CNT_W-1:0] r_k;
    lmkg_pkg::t_mul_req w_req;
    lmkg_pkg::t_mul_rsp w_rsp;
    logic r_done_d;
    logic [lmkg_pkg::CNT_W-1:0] w_n;
    logic w_acc;
    logic w_last;
    logic w_emit;

    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_n = r_counts[{r_rnd, 2'b00} +: lmkg_pkg::CNT_W];
    assign w_req.start = (r_state == S_START);
    assign w_req.x = r_st[255:128];
    assign w_last = (r_state == S_WRITE) && (r_k == w_n) && (r_rnd == lmkg_pkg::LAST_RND);
    // key write-back waits only while the previous key is still held
    assign w_emit = w_last && (!m_axis_tvalid || m_axis_tready);

    lmkg_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_counts <= '1;
            r_st <= '0;
            m_axis_tvalid <= 1'b0;
            r_done_d <= 1'b0;
            r_rnd <= '0;
            r_k <= '0;
        end else begin
            if (i_cfg_we) r_counts <= i_cfg_wdata;
            if (w_emit) m_axis_tvalid <= 1'b1;
            else if (m_axis_tready) m_axis_tvalid <= 1'b0;
            r_done_d <= w_rsp.done;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (s_axis_tuser == lmkg_pkg::ACT_LOAD) begin
                            case (s_axis_tdata[1:0])
                                2'd0:    r_st[255:192] <= s_axis_tdata[65:2];
                                2'd1:    r_st[191:128] <= s_axis_tdata[65:2];
                                2'd2:    r_st[127:64] <= s_axis_tdata[65:2];
                                default: r_st[63:0] <= s_axis_tdata[65:2];
                            endcase
                        end else begin
                            r_rnd <= '0;
                            r_k <= '0;
                            r_state <= S_START;
                        end
                    end
                end
                S_START: r_state <= S_WAIT;
                S_WAIT: if (r_done_d) begin
                    r_st <= w_rsp.prod;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (r_k == w_n) begin
                        if (r_rnd == lmkg_pkg::LAST_RND) begin
                            if (w_emit) begin
                                r_k <= '0;
                                m_axis_tdata <= {r_st[191:128] ^ r_st[63:0],
                                                 r_st[255:192] ^ r_st[127:64]};
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_k <= '0;
                            r_rnd <= r_rnd + 1'b1;
                            r_state <= S_START;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_START;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE)
        else $error("ready outside idle");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT |-> !s_axis_tready)
        else $error("accept during map step");
    a_key_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_WRITE)
        else $error("key without generate");
    a_key_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("key changed while stalled");
endmodule

>>> sim/logistic_map_key_generator_tb.sv
// testbench for the logistic map key generator: directed table and random items
`timescale 1ns / 100ps

module logistic_map_key_generator_tb;

    typedef struct packed {
        logic        act;
        logic [1:0]  part;
        logic [63:0] val;
        logic        typed;   // key given below instead of predicted
        logic [127:0] key;
    } t_row;

    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] HALF = 64'h8000_0000_0000_0000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [63:0]  i_cfg_wdata = '0;

    logistic_map_key_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of the block
    logic [63:0]  chaos_words [4];
    logic [63:0]  round_nibbles;
    logic [127:0] pending_keys [$];   // tdata form: {key_low, key_high}

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recv_hold_left = 0;
    int mismatches = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;

    t_row dir_rows [16] = '{
        '{lmkg_pkg::ACT_GEN,  2'd0, 64'd0, 1'b1, 128'd0},   // zero state gives zero key
        '{lmkg_pkg::ACT_LOAD, 2'd0, ONES,  1'b0, 128'd0},
        '{lmkg_pkg::ACT_LOAD, 2'd1, ONES,  1'b0, 128'd0},
        '{lmkg_pkg::ACT_LOAD, 2'd2, ONES,  1'b0, 128'd0},
        '{lmkg_pkg::ACT_LOAD, 2'd3, ONES,  1'b0, 128'd0},
        '{lmkg_pkg::ACT_GEN,  2'd0, 64'd0, 1'b0, 128'd0},
        '{lmkg_pkg::ACT_LOAD, 2'd0, HALF,  1'b0, 128'd0},
        '{lmkg_pkg::ACT_LOAD, 2'd1, 64'd0, 1'b0, 128'd0},
        // x one half maps to exactly one, wraps to zero
        '{lmkg_pkg::ACT_GEN,  2'd3, ONES,  1'b1, 128'd0},
        '{lmkg_pkg::ACT_LOAD, 2'd2, ONES,  1'b0, 128'd0},
        '{lmkg_pkg::ACT_LOAD, 2'd3, 64'h0123_4567_89ab_cdef, 1'b0, 128'd0},
        // zero fraction clears the lower half too
        '{lmkg_pkg::ACT_GEN,  2'd1, 64'd0, 1'b1, 128'd0},
        '{lmkg_pkg::ACT_LOAD, 2'd1, 64'd1, 1'b0, 128'd0},
        '{lmkg_pkg::ACT_GEN,  2'd2, 64'd0, 1'b0, 128'd0},
        '{lmkg_pkg::ACT_LOAD, 2'd0, 64'h5555_aaaa_3333_cccc, 1'b0, 128'd0},
        '{lmkg_pkg::ACT_GEN,  2'd0, 64'd0, 1'b0, 128'd0}
    };

    function automatic void logistic_step();
        logic [127:0] x, c;
        logic [255:0] p;
        x = {chaos_words[0], chaos_words[1]};
        c = -x;
        p = {128'd0, x} * {128'd0, c};
        p = p << 2;
        chaos_words[0] = p[255:192];
        chaos_words[1] = p[191:128];
        chaos_words[2] = p[127:64];
        chaos_words[3] = p[63:0];
    endfunction

    // returns the key in tdata form; only meaningful for a generate
    function automatic logic [127:0] apply_item(logic act, logic [1:0] part, logic [63:0] val);
        int n;
        if (act == lmkg_pkg::ACT_LOAD) begin
            chaos_words[part] = val;
            return '0;
        end
        for (int r = 0; r < lmkg_pkg::ROUNDS; r++) begin
            n = int'(round_nibbles[4*(r%16) +: 4]);
            for (int k = 0; k <= n; k++) logistic_step();
        end
        return {chaos_words[1] ^ chaos_words[3], chaos_words[0] ^ chaos_words[2]};
    endfunction

    task automatic send_item(logic act, logic [1:0] part, logic [63:0] val, logic typed = 1'b0,
                             logic [127:0] typed_key = '0);
        logic [127:0] k;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'd0, val, part};
        do @(posedge i_clk); while (!s_axis_tready);
        k = apply_item(act, part, val);
        if (act == lmkg_pkg::ACT_GEN) pending_keys.push_back(typed ? typed_key : k);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_keys.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_counts(logic [63:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        round_nibbles = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_seed();
        case ($urandom_range(9))
            0: return '0;
            1: return ONES;
            2: return HALF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver side
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            recv_hold_left <= 4000;
            m_axis_tready <= 1'b0;
        end else if (recv_hold_left > 0) begin
            recv_hold_left <= recv_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // key checking
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_keys.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected key %h", m_axis_tdata);
            end else begin
                if (m_axis_tdata[63:0] !== pending_keys[0][63:0] ||
                    m_axis_tdata[127:64] !== pending_keys[0][127:64]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("key mismatch: expected high %h low %h, got high %h low %h",
                                 pending_keys[0][63:0], pending_keys[0][127:64],
                                 m_axis_tdata[63:0], m_axis_tdata[127:64]);
                end
                void'(pending_keys.pop_front());
            end
        end
    end

    initial begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [63:0] phase_counts [5];
        int phase_idle [5][2];
        int sent;
        phase_counts = '{64'd0, ONES, {$urandom, $urandom} & 64'h3333_3333_3333_3333,
                         {$urandom, $urandom}, 64'h0000_0000_0000_000f};
        phase_idle = '{'{0, 0}, '{83, 0}, '{0, 83}, '{25, 25}, '{0, 0}};
        round_nibbles = ONES;
        for (int i = 0; i < 4; i++) chaos_words[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].part, dir_rows[i].val,
                      dir_rows[i].typed, dir_rows[i].key);

        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            write_counts(phase_counts[ph]);
            send_idle_pct  = phase_idle[ph][0];
            recv_stall_pct = phase_idle[ph][1];
            if (ph == 4) hold_req = ~hold_req;   // long hold-off while loads and keys queue up
            sent = 0;
            while (sent < 104) begin
                if (ph == 1 && sent == 50) wait_drained();
                if ($urandom_range(99) < 70) begin
                    // full reseed in part order, then a key
                    for (int p = 0; p < 4; p++)
                        send_item(lmkg_pkg::ACT_LOAD, 2'(p), pick_seed());
                    send_item(lmkg_pkg::ACT_GEN, 2'($urandom_range(3)), {$urandom, $urandom});
                    sent += 5;
                end else begin
                    send_item(1'($urandom_range(1)), 2'($urandom_range(3)), pick_seed());
                    sent++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending_keys.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/lmkg_pkg.sv
hw/rtl/lmkg_mul.sv
hw/rtl/logistic_map_key_generator.sv
sim/logistic_map_key_generator_tb.sv
